>>> hdl/linear_queue_with_statistics_defines.svh
// Assertion macros for the linear queue with statistics block
// No dependencies; included by the files that assert
`ifndef LINEAR_QUEUE_WITH_STATISTICS_DEFINES_SVH
`define LINEAR_QUEUE_WITH_STATISTICS_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, disabled in reset
`define LQS_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled in reset
`define LQS_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LQS_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons, msg)
`define LQS_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons, msg)
`endif
`endif

>>> hdl/lqs_pkg.sv
// Shared constants and types for the linear queue with statistics block
// No dependencies
`timescale 1ns / 1ps
package lqs_pkg;

  // storage geometry
  localparam int DEPTH = 128;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;

  // word and arithmetic widths
  localparam int WORD_W    = 32;
  localparam int SUM_W     = WORD_W + IDX_W;
  localparam int FRAC_W    = 8;
  localparam int DVD_W     = SUM_W + FRAC_W;
  localparam int MEAN_W    = 40;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // command codes
  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_DEQ = 2'd1;
  localparam logic [1:0] CMD_QRY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic enq;
    logic deq;
    logic walk_init;
    logic walk_step;
    logic div_go;
    logic post;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] cmd;
    logic       empty;
    logic       walk_last;
    logic       div_done;
  } dp_stat_t;

endpackage

>>> hdl/linear_queue_with_statistics.sv
// Top level of the linear queue with statistics block
// Depends on lqs_pkg, lqs_ctrl, lqs_dp, lqs_div and linear_queue_with_statistics_defines.svh
`timescale 1ns / 1ps
`include "linear_queue_with_statistics_defines.svh"

// A word is taken when start is high and busy is low; its one result appears
// on the out_ ports for a single cycle with out_valid high and cannot be held
// off, so the receiver must take it then. Enqueue, dequeue and unused command
// codes pass through the execute and post states only, and the next word may be
// started in the cycle the result is shown. A query over held words walks them
// and then divides: the store has one read port and gives one entry per cycle,
// and the mean comes from a restoring divider that yields one quotient bit per
// cycle. Full and empty conditions are reported in out_status, never as a
// stall.
module linear_queue_with_statistics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_head_word,
  output logic signed [31:0] out_max_word,
  output logic signed [31:0] out_min_word,
  output logic signed [39:0] out_mean_q8
);

  lqs_pkg::ctrl_cmd_t cmd;
  lqs_pkg::dp_stat_t  stat;
  logic               out_data_zero;

  lqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  lqs_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_command    (in_command),
    .in_value      (in_value),
    .res_status    (out_status),
    .res_head_word (out_head_word),
    .res_max_word  (out_max_word),
    .res_min_word  (out_min_word),
    .res_mean_q8   (out_mean_q8)
  );

  // all data words of the result are zero
  assign out_data_zero = (out_head_word == '0) && (out_max_word == '0) &&
                         (out_min_word == '0) && (out_mean_q8 == '0);

  // a result never shows in the cycle right after a word is taken
  `LQS_ASSERT_NXT(a_no_early_result, clk, rst_n, start && !busy, !out_valid, "result too early")
  // a result is shown only once the controller is back in idle
  `LQS_ASSERT_IMP(a_result_when_idle, clk, rst_n, out_valid, !busy, "result while busy")
  // a rejected command carries zero data words
  `LQS_ASSERT_IMP(a_reject_zero, clk, rst_n, out_valid && (out_status != lqs_pkg::ST_OK), out_data_zero, "rejected word carries data")

endmodule

>>> hdl/lqs_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands
// Depends on lqs_pkg
`timescale 1ns / 1ps
module lqs_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic [lqs_pkg::DVD_W-1:0] dividend,
  input  logic [lqs_pkg::CNT_W-1:0] divisor,
  output logic                     done,
  output logic [lqs_pkg::DVD_W-1:0] quotient
);

  logic [lqs_pkg::DVD_W-1:0]     quo_r;
  logic [lqs_pkg::CNT_W-1:0]     rem_r;
  logic [lqs_pkg::CNT_W-1:0]     dsr_r;
  logic [lqs_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          done_r;
  logic [lqs_pkg::CNT_W:0]       rem_sh;
  logic                          fits;

  // shift in the next dividend bit and trial subtract
  always_comb begin
    rem_sh = {rem_r, quo_r[lqs_pkg::DVD_W-1]};
    fits   = (rem_sh >= {1'b0, dsr_r});
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (go) begin
      cnt_r  <= lqs_pkg::DIV_CNT_W'(lqs_pkg::DVD_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == lqs_pkg::DIV_CNT_W'(1)) begin
        done_r <= 1'b1;
      end
    end
  end

  // remainder and quotient, remainder stays below the divisor
  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[lqs_pkg::DVD_W-2:0], fits};
      rem_r <= lqs_pkg::CNT_W'(fits ? (rem_sh - {1'b0, dsr_r}) : rem_sh);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hdl/lqs_dp.sv
// Datapath: word store, head and tail indices, statistics walk and result words
// Depends on lqs_pkg and lqs_div
`timescale 1ns / 1ps
module lqs_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lqs_pkg::ctrl_cmd_t          cmd,
  output lqs_pkg::dp_stat_t           stat,
  input  logic [1:0]                  in_command,
  input  logic signed [31:0]          in_value,
  output logic [1:0]                  res_status,
  output logic signed [31:0]          res_head_word,
  output logic signed [31:0]          res_max_word,
  output logic signed [31:0]          res_min_word,
  output logic signed [39:0]          res_mean_q8
);

  logic [lqs_pkg::WORD_W-1:0] mem [lqs_pkg::DEPTH];

  logic [1:0]                       cmd_r;
  logic signed [31:0]               value_r;
  logic [lqs_pkg::IDX_W-1:0]        head_r;
  logic [lqs_pkg::IDX_W-1:0]        tail_r;
  logic                             empty_r;
  logic [1:0]                       status_r;
  logic [lqs_pkg::IDX_W-1:0]        ptr_r;
  logic                             rd_vld_r;
  logic signed [31:0]               rd_data_r;
  logic                             first_r;
  logic signed [31:0]               max_r;
  logic signed [31:0]               min_r;
  logic signed [lqs_pkg::SUM_W-1:0] sum_r;
  logic [lqs_pkg::CNT_W-1:0]        count_r;
  logic                             neg_r;
  logic [1:0]                       out_status_r;
  logic signed [31:0]               out_head_r;
  logic signed [31:0]               out_max_r;
  logic signed [31:0]               out_min_r;
  logic signed [39:0]               out_mean_r;

  logic                             full;
  logic                             wr_en;
  logic [lqs_pkg::IDX_W-1:0]        wr_addr;
  logic                             rd_en;
  logic [lqs_pkg::IDX_W-1:0]        rd_addr;
  logic [lqs_pkg::SUM_W-1:0]        sum_mag;
  logic [lqs_pkg::DVD_W-1:0]        dividend;
  logic                             div_done;
  logic [lqs_pkg::DVD_W-1:0]        quotient;
  logic [lqs_pkg::MEAN_W-1:0]       q_low;
  logic                             ok;

  // queue flags and store port selection
  always_comb begin
    full     = !empty_r && (tail_r == lqs_pkg::IDX_W'(lqs_pkg::DEPTH - 1));
    wr_en    = cmd.enq && !full;
    wr_addr  = empty_r ? '0 : tail_r + lqs_pkg::IDX_W'(1);
    rd_en    = (cmd.deq && !empty_r) || cmd.walk_step;
    rd_addr  = cmd.walk_step ? ptr_r : head_r;
    sum_mag  = sum_r[lqs_pkg::SUM_W-1] ? lqs_pkg::SUM_W'(-sum_r) : lqs_pkg::SUM_W'(sum_r);
    dividend = {sum_mag, {lqs_pkg::FRAC_W{1'b0}}};
    q_low    = quotient[lqs_pkg::MEAN_W-1:0];
    ok       = (status_r == lqs_pkg::ST_OK);
  end

  // word store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // latched item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_command;
      value_r <= in_value;
    end
  end

  // status of the item, taken before the indices move
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (cmd_r)
        lqs_pkg::CMD_ENQ: status_r <= full ? lqs_pkg::ST_FULL : lqs_pkg::ST_OK;
        lqs_pkg::CMD_DEQ,
        lqs_pkg::CMD_QRY: status_r <= empty_r ? lqs_pkg::ST_EMPTY : lqs_pkg::ST_OK;
        default:          status_r <= lqs_pkg::ST_OK;
      endcase
    end
  end

  // head and tail indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (cmd.enq) begin
      if (empty_r) begin
        head_r  <= '0;
        tail_r  <= '0;
        empty_r <= 1'b0;
      end else if (!full) begin
        tail_r <= tail_r + lqs_pkg::IDX_W'(1);
      end
    end else if (cmd.deq && !empty_r) begin
      if (head_r == tail_r) begin
        head_r  <= '0;
        tail_r  <= '0;
        empty_r <= 1'b1;
      end else begin
        head_r <= head_r + lqs_pkg::IDX_W'(1);
      end
    end
  end

  // walk pointer and read-data valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.walk_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      ptr_r <= head_r;
    end else if (cmd.walk_step) begin
      ptr_r <= ptr_r + lqs_pkg::IDX_W'(1);
    end
  end

  // running maximum, minimum, sum and count
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      first_r <= 1'b1;
      sum_r   <= '0;
      count_r <= '0;
    end else if (rd_vld_r) begin
      if (first_r || (rd_data_r > max_r)) begin
        max_r <= rd_data_r;
      end
      if (first_r || (rd_data_r < min_r)) begin
        min_r <= rd_data_r;
      end
      first_r <= 1'b0;
      sum_r   <= sum_r + lqs_pkg::SUM_W'(rd_data_r);
      count_r <= count_r + lqs_pkg::CNT_W'(1);
    end
  end

  // sign of the mean, divider works on the magnitude
  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      neg_r <= sum_r[lqs_pkg::SUM_W-1];
    end
  end

  lqs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (dividend),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // result words, zero where the command or status gives none
  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_status_r <= status_r;
      out_head_r   <= (ok && (cmd_r == lqs_pkg::CMD_DEQ)) ? rd_data_r : '0;
      if (ok && (cmd_r == lqs_pkg::CMD_QRY)) begin
        out_max_r  <= max_r;
        out_min_r  <= min_r;
        out_mean_r <= neg_r ? -$signed(q_low) : $signed(q_low);
      end else begin
        out_max_r  <= '0;
        out_min_r  <= '0;
        out_mean_r <= '0;
      end
    end
  end

  assign stat.cmd       = cmd_r;
  assign stat.empty     = empty_r;
  assign stat.walk_last = (ptr_r == tail_r);
  assign stat.div_done  = div_done;

  assign res_status    = out_status_r;
  assign res_head_word = out_head_r;
  assign res_max_word  = out_max_r;
  assign res_min_word  = out_min_r;
  assign res_mean_q8   = out_mean_r;

endmodule

>>> hdl/lqs_ctrl.sv
// Controller: sequences enqueue, dequeue and the statistics query
// Depends on lqs_pkg
`timescale 1ns / 1ps
module lqs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output lqs_pkg::ctrl_cmd_t cmd,
  input  lqs_pkg::dp_stat_t  stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DRAIN,
    S_DIV_GO,
    S_DIV_WAIT,
    S_POST
  } state_t;

  state_t state_r;
  logic   valid_r;

  // commands decoded from the state
  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && start;
    cmd.exec      = (state_r == S_EXEC);
    cmd.enq       = (state_r == S_EXEC) && (stat.cmd == lqs_pkg::CMD_ENQ);
    cmd.deq       = (state_r == S_EXEC) && (stat.cmd == lqs_pkg::CMD_DEQ);
    cmd.walk_init = (state_r == S_EXEC) && (stat.cmd == lqs_pkg::CMD_QRY);
    cmd.walk_step = (state_r == S_WALK);
    cmd.div_go    = (state_r == S_DIV_GO);
    cmd.post      = (state_r == S_POST);
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      valid_r <= (state_r == S_POST);
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if ((stat.cmd == lqs_pkg::CMD_QRY) && !stat.empty) begin
            state_r <= S_WALK;
          end else begin
            state_r <= S_POST;
          end
        end
        S_WALK: begin
          if (stat.walk_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN:  state_r <= S_DIV_GO;
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (stat.div_done) begin
            state_r <= S_POST;
          end
        end
        S_POST:   state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

>>> dv/tb.sv
// Self-checking bench for linear_queue_with_statistics: directed and random
// enqueue, dequeue and query words checked against a behavioural queue model
// Depends on lqs_pkg and the linear_queue_with_statistics RTL
`timescale 1ns / 1ps

module tb;

  // unused command code, must be ignored by the block
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  localparam int ITEMS       = 1600;
  localparam int SETTLE      = 250;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] head_word;
    logic signed [31:0] max_word;
    logic signed [31:0] min_word;
    logic signed [39:0] mean_q8;
  } queue_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_command;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic [1:0]         out_status;
  logic signed [31:0] out_head_word;
  logic signed [31:0] out_max_word;
  logic signed [31:0] out_min_word;
  logic signed [39:0] out_mean_q8;

  // model of the queue contents
  logic signed [31:0] mdl_store [lqs_pkg::DEPTH];
  int                 mdl_head;
  int                 mdl_tail;
  bit                 mdl_empty;

  queue_result_t pending_results [$];
  int            fail_count;
  int            words_sent;
  int            cycle_count;
  bit            gaps_on;

  linear_queue_with_statistics u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_head_word (out_head_word),
    .out_max_word  (out_max_word),
    .out_min_word  (out_min_word),
    .out_mean_q8   (out_mean_q8)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // apply one command to the queue model and return the expected result
  function automatic queue_result_t queue_step(input logic [1:0] cmd,
                                               input logic signed [31:0] val);
    queue_result_t res;
    longint        acc;
    longint        cnt;
    longint        mean;
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    res = '0;
    case (cmd)
      lqs_pkg::CMD_ENQ: begin
        if (mdl_empty) begin
          mdl_head     = 0;
          mdl_tail     = 0;
          mdl_store[0] = val;
          mdl_empty    = 1'b0;
        end else if (mdl_tail >= lqs_pkg::DEPTH - 1) begin
          res.status = lqs_pkg::ST_FULL;
        end else begin
          mdl_tail++;
          mdl_store[mdl_tail] = val;
        end
      end
      lqs_pkg::CMD_DEQ: begin
        if (mdl_empty) begin
          res.status = lqs_pkg::ST_EMPTY;
        end else begin
          res.head_word = mdl_store[mdl_head];
          if (mdl_head >= mdl_tail) begin
            mdl_head  = 0;
            mdl_tail  = 0;
            mdl_empty = 1'b1;
          end else begin
            mdl_head++;
          end
        end
      end
      lqs_pkg::CMD_QRY: begin
        if (mdl_empty) begin
          res.status = lqs_pkg::ST_EMPTY;
        end else begin
          hi  = mdl_store[mdl_head];
          lo  = hi;
          acc = 0;
          for (int i = mdl_head; i <= mdl_tail; i++) begin
            if (mdl_store[i] > hi) hi = mdl_store[i];
            if (mdl_store[i] < lo) lo = mdl_store[i];
            acc += longint'(mdl_store[i]);
          end
          cnt  = longint'(mdl_tail - mdl_head + 1);
          // signed division truncates toward zero
          mean = (acc * 256) / cnt;
          res.max_word = hi;
          res.min_word = lo;
          res.mean_q8  = mean[39:0];
        end
      end
      default: begin
        res = '0;
      end
    endcase
    return res;
  endfunction

  // biased word choice so the extremes turn up often
  function automatic logic signed [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return 32'(signed'($urandom_range(0, 6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  // send one word, with an optional idle burst first
  task automatic issue_word(input logic [1:0] cmd, input logic signed [31:0] val);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(queue_step(cmd, val));
    if (cmd != CMD_NOP) words_sent++;
  endtask

  // hold the sender until every outstanding result is back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst_n && out_valid) begin
      got = '{out_status, out_head_word, out_max_word, out_min_word, out_mean_q8};
      if (pending_results.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("unexpected result: status %0d head %0d max %0d min %0d mean %0d",
                   got.status, got.head_word, got.max_word, got.min_word,
                   got.mean_q8);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (fail_count < REPORT_MAX) begin
            $display("mismatch: expected status %0d head %0d max %0d min %0d mean %0d",
                     want.status, want.head_word, want.max_word, want.min_word,
                     want.mean_q8);
            $display("          got      status %0d head %0d max %0d min %0d mean %0d",
                     got.status, got.head_word, got.max_word, got.min_word,
                     got.mean_q8);
          end
          fail_count++;
        end
      end
    end
  end

  // rejected and unused commands on a queue that has never held a word
  task automatic test_empty_queue();
    issue_word(lqs_pkg::CMD_DEQ, WORD_MAX);
    issue_word(lqs_pkg::CMD_QRY, WORD_MIN);
    issue_word(CMD_NOP, 32'sd0);
    issue_word(CMD_NOP, -32'sd1);
  endtask

  // extreme words, last-word drain and a mean that needs truncation
  task automatic test_extreme_words();
    issue_word(lqs_pkg::CMD_ENQ, WORD_MAX);
    issue_word(lqs_pkg::CMD_ENQ, WORD_MIN);
    issue_word(lqs_pkg::CMD_ENQ, 32'sd0);
    issue_word(lqs_pkg::CMD_ENQ, -32'sd1);
    issue_word(lqs_pkg::CMD_QRY, 32'sd0);
    issue_word(CMD_NOP, WORD_MAX);
    issue_word(lqs_pkg::CMD_DEQ, 32'sd0);
    issue_word(lqs_pkg::CMD_QRY, 32'sd0);
    issue_word(lqs_pkg::CMD_DEQ, 32'sd0);
    issue_word(lqs_pkg::CMD_DEQ, 32'sd0);
    issue_word(lqs_pkg::CMD_DEQ, 32'sd0);
    issue_word(lqs_pkg::CMD_DEQ, 32'sd0);
    issue_word(lqs_pkg::CMD_QRY, 32'sd0);
    // -1/3 of a unit, truncates toward zero
    issue_word(lqs_pkg::CMD_ENQ, -32'sd1);
    issue_word(lqs_pkg::CMD_ENQ, 32'sd0);
    issue_word(lqs_pkg::CMD_ENQ, 32'sd0);
    issue_word(lqs_pkg::CMD_QRY, WORD_MAX);
    issue_word(lqs_pkg::CMD_DEQ, 32'sd0);
    issue_word(lqs_pkg::CMD_DEQ, 32'sd0);
    issue_word(lqs_pkg::CMD_QRY, 32'sd0);
    issue_word(lqs_pkg::CMD_DEQ, 32'sd0);
  endtask

  // fill to the last slot with one extreme, then probe full and drain
  task automatic test_full_queue(input logic signed [31:0] fill_word);
    for (int i = 0; i < lqs_pkg::DEPTH; i++) issue_word(lqs_pkg::CMD_ENQ, fill_word);
    issue_word(lqs_pkg::CMD_QRY, 32'sd0);
    issue_word(lqs_pkg::CMD_ENQ, 32'sd5);
    issue_word(lqs_pkg::CMD_DEQ, 32'sd0);
    issue_word(lqs_pkg::CMD_DEQ, 32'sd0);
    // head has moved but the tail still sits in the last slot
    issue_word(lqs_pkg::CMD_ENQ, ~fill_word);
    issue_word(lqs_pkg::CMD_QRY, 32'sd0);
    while (!mdl_empty) issue_word(lqs_pkg::CMD_DEQ, pick_word());
    issue_word(lqs_pkg::CMD_DEQ, 32'sd0);
  endtask

  // fill to a random level, then drain, with queries and noise mixed in
  task automatic run_episode();
    int          fill;
    int          enq_seen;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70)      fill = $urandom_range(1, 16);
    else if (r < 90) fill = $urandom_range(17, 100);
    else             fill = lqs_pkg::DEPTH + $urandom_range(1, 6);
    enq_seen = 0;
    while (enq_seen < fill && words_sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        issue_word(lqs_pkg::CMD_ENQ, pick_word());
        enq_seen++;
      end else if (r < 88) begin
        issue_word(lqs_pkg::CMD_QRY, $urandom);
      end else if (r < 96) begin
        issue_word(lqs_pkg::CMD_DEQ, $urandom);
      end else begin
        issue_word(CMD_NOP, $urandom);
      end
    end
    while (!mdl_empty && words_sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 78)      issue_word(lqs_pkg::CMD_DEQ, $urandom);
      else if (r < 90) issue_word(lqs_pkg::CMD_QRY, $urandom);
      else if (r < 96) issue_word(lqs_pkg::CMD_ENQ, pick_word());
      else             issue_word(CMD_NOP, $urandom);
    end
    // a rejected word on the drained queue now and then
    if ($urandom_range(0, 2) == 0)
      issue_word($urandom_range(0, 1) ? lqs_pkg::CMD_DEQ : lqs_pkg::CMD_QRY, $urandom);
  endtask

  task automatic test_random_traffic();
    while (words_sent < ITEMS) begin
      if (words_sent > ITEMS * 85 / 100) gaps_on = 1'b0;
      else                               gaps_on = ($urandom_range(0, 9) < 7);
      run_episode();
      if (gaps_on && $urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_command  <= lqs_pkg::CMD_ENQ;
    in_value    <= '0;
    fail_count  = 0;
    words_sent  = 0;
    cycle_count = 0;
    gaps_on     = 1'b1;
    mdl_head    = 0;
    mdl_tail    = 0;
    mdl_empty   = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_extreme_words();
    wait_drained();
    test_full_queue(WORD_MAX);
    test_full_queue(WORD_MIN);
    wait_drained();
    test_random_traffic();

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
